// ===== hdl/slil_pkg.sv =====
package slil_pkg;

  localparam int SLIL_CAPACITY = 64;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 6;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 3;
  localparam int COUNT_OUT_W   = 7;

  typedef enum logic [KIND_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_READ_DONE = 3'd5
  } status_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                      eval;
    logic                      shift_ins;
    logic                      shift_del;
    logic signed [VALUE_W-1:0] val;
  } cell_ctl_t;

  // compare results held in each cell between evaluate and apply
  typedef struct packed {
    logic after;  // insert slot lies at or before this cell
    logic ge;     // live entry >= value
    logic eq;     // entry == value
    logic pick;   // read position hits this cell
  } cell_flag_t;

endpackage

// ===== hdl/slil_cell.sv =====
module slil_cell (
  input  logic                               clk,
  input  slil_pkg::cell_ctl_t                ctl,
  input  logic                               live,
  input  logic                               pick,
  input  logic signed [slil_pkg::VALUE_W-1:0] left_value,
  input  slil_pkg::cell_flag_t               left_flag,
  input  logic signed [slil_pkg::VALUE_W-1:0] right_value,
  output logic signed [slil_pkg::VALUE_W-1:0] value,
  output slil_pkg::cell_flag_t               flag,
  output logic                               match,
  output logic        [slil_pkg::VALUE_W-1:0] rd_term
);
  import slil_pkg::*;

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  cell_flag_t                flag_r, flag_nxt;

  always_comb begin
    flag_nxt = flag_r;
    if (ctl.eval) begin
      flag_nxt.after = !(live && (value_r <= ctl.val));
      flag_nxt.ge    = live && (value_r >= ctl.val);
      flag_nxt.eq    = (value_r == ctl.val);
      flag_nxt.pick  = pick;
    end
  end

  // insert: shift right from the slot on; delete: shift left from the match on
  always_comb begin
    value_nxt = value_r;
    priority if (ctl.shift_ins && flag_r.after) begin
      value_nxt = left_flag.after ? left_value : ctl.val;
    end else if (ctl.shift_del && flag_r.ge) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    flag_r  <= flag_nxt;
  end

  assign value   = value_r;
  assign flag    = flag_r;
  // first entry >= value that is also equal: the one to delete
  assign match   = flag_r.ge && !left_flag.ge && flag_r.eq;
  assign rd_term = flag_r.pick ? value_r : '0;

endmodule

// ===== hdl/sorted_list_insert_delete.sv =====
// Sorted list of signed 32-bit values, ascending, up to CAPACITY entries.
// Input channel (in_*): one request per beat. in_tuser carries the request
// kind (insert, delete, clear, read); in_tdata carries the value and the
// read position. Output channel (out_*): exactly one result beat per
// request, carrying status and read-valid in out_tuser, entry count and
// read value in out_tdata.
// The list lives in a row of CAPACITY cells, one entry each. A request
// passes through an accept step, an evaluate step in which every cell
// compares its entry with the request value at once, and an apply step
// in which cells shift one place left or right and the result is
// registered. A new request is taken only after the previous one has
// left the apply step, as the compare/shift sequence through the cell
// row serves one request at a time.
// If the receiver stalls, the result waits in the output register; one
// further request is accepted and evaluated, then held until it drains.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// request or result; cell contents are not cleared.
module sorted_list_insert_delete #(
  parameter int CAPACITY = slil_pkg::SLIL_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [37:32] position, [39:38] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [6:0] entry_count, [38:7] read_value, [39] zero
  output logic [3:0]  out_tuser   // [2:0] status, [3] read_valid
);
  import slil_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // request held for the evaluate and apply cycles
  req_t                      req_r,  req_nxt;
  logic signed [VALUE_W-1:0] val_r,  val_nxt;
  logic        [POS_W-1:0]   pos_r,  pos_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;

  // output register
  logic                      ovalid_r, ovalid_nxt;
  status_t                   ostat_r,  ostat_nxt;
  logic [CNT_W-1:0]          ocount_r, ocount_nxt;
  logic [VALUE_W-1:0]        oval_r,   oval_nxt;
  logic                      ordv_r,   ordv_nxt;

  // cell row
  cell_ctl_t                 ctl;
  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  cell_flag_t                cell_flag  [CAPACITY];
  logic        [CAPACITY-1:0] cell_match;
  logic        [CAPACITY-1:0] cell_pick;
  logic        [VALUE_W-1:0] cell_rd    [CAPACITY];

  logic               in_fire;
  logic               out_free;
  logic               do_apply;
  logic               full;
  logic               found;
  logic               rd_hit;
  logic [VALUE_W-1:0] rd_value;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;
  assign do_apply  = (state_r == S_APPLY) && out_free;
  assign full      = (count_r == CNT_W'(CAPACITY));

  assign ctl.eval      = (state_r == S_EVAL);
  assign ctl.shift_ins = do_apply && (req_r == REQ_INSERT) && !full;
  assign ctl.shift_del = do_apply && (req_r == REQ_DELETE) && found;
  assign ctl.val       = val_r;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                      live;
      logic signed [VALUE_W-1:0] lval;
      cell_flag_t                lflag;
      logic signed [VALUE_W-1:0] rval;

      assign live = (count_r > CNT_W'(gi));

      if (gi == 0) begin : g_head
        assign lval  = '0;
        assign lflag = '0;
      end else begin : g_body
        assign lval  = cell_value[gi-1];
        assign lflag = cell_flag[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign rval = cell_value[gi];
      end else begin : g_mid
        assign rval = cell_value[gi+1];
      end

      slil_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .live        (live),
        .pick        (cell_pick[gi]),
        .left_value  (lval),
        .left_flag   (lflag),
        .right_value (rval),
        .value       (cell_value[gi]),
        .flag        (cell_flag[gi]),
        .match       (cell_match[gi]),
        .rd_term     (cell_rd[gi])
      );

      assign cell_pick[gi] = live && (int'(pos_r) == gi);
    end
  endgenerate

  // read collection: at most one cell has its pick flag set
  always_comb begin
    rd_hit   = 1'b0;
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_hit   = rd_hit | cell_flag[i].pick;
      rd_value = rd_value | cell_rd[i];
    end
  end

  assign found = |cell_match;

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    ovalid_nxt = ovalid_r;
    ostat_nxt  = ostat_r;
    ocount_nxt = ocount_r;
    oval_nxt   = oval_r;
    ordv_nxt   = ordv_r;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt   = req_t'(in_tuser);
          val_nxt   = in_tdata[VALUE_W-1:0];
          pos_nxt   = in_tdata[VALUE_W +: POS_W];
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          oval_nxt = '0;
          ordv_nxt = 1'b0;
          unique case (req_r)
            REQ_INSERT: begin
              if (full) begin
                ostat_nxt = ST_FULL;
              end else begin
                ostat_nxt = ST_INSERTED;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_DELETE: begin
              if (found) begin
                ostat_nxt = ST_DELETED;
                count_nxt = count_r - CNT_W'(1);
              end else begin
                ostat_nxt = ST_NOT_FOUND;
              end
            end
            REQ_CLEAR: begin
              ostat_nxt = ST_CLEARED;
              count_nxt = '0;
            end
            REQ_READ: begin
              ostat_nxt = ST_READ_DONE;
              oval_nxt  = rd_value;
              ordv_nxt  = rd_hit;
            end
            default: begin
              ostat_nxt = ST_READ_DONE;
            end
          endcase
          ocount_nxt = count_nxt;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    ostat_r  <= ostat_nxt;
    ocount_r <= ocount_nxt;
    oval_r   <= oval_nxt;
    ordv_r   <= ordv_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, oval_r, COUNT_OUT_W'(ocount_r)};
  assign out_tuser  = {ordv_r, ostat_r};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import slil_pkg::*;

  // one result beat as the list should report it
  typedef struct {
    status_t            status;
    logic [6:0]         count;
    logic signed [31:0] rd_value;
    logic               rd_valid;
  } list_result_t;

  // Scoreboard: keeps its own sorted copy of the list and a queue of
  // results still owed by the block.
  class list_scoreboard;
    logic signed [31:0] held [SLIL_CAPACITY];
    int                 held_n;
    list_result_t       owed_q [$];
    int                 errors;
    int                 kind_hits [4];
    int                 full_drops;
    int                 misses;
    int                 good_reads;

    function new();
      held_n     = 0;
      errors     = 0;
      full_drops = 0;
      misses     = 0;
      good_reads = 0;
      foreach (kind_hits[k]) kind_hits[k] = 0;
    endfunction

    // accepted request beat: update the list copy, queue the result
    function void note_request(req_t kind, logic signed [31:0] v, logic [5:0] pos);
      list_result_t r;
      int           slot;
      r.status   = ST_INSERTED;
      r.rd_value = '0;
      r.rd_valid = 1'b0;
      kind_hits[kind]++;
      case (kind)
        REQ_INSERT: begin
          if (held_n >= SLIL_CAPACITY) begin
            r.status = ST_FULL;
            full_drops++;
          end else begin
            // equal values keep arrival order: skip past every entry <= v
            slot = 0;
            while (slot < held_n && held[slot] <= v) slot++;
            for (int i = held_n; i > slot; i--) held[i] = held[i-1];
            held[slot] = v;
            held_n++;
          end
        end
        REQ_DELETE: begin
          slot = 0;
          while (slot < held_n && held[slot] != v) slot++;
          if (slot < held_n) begin
            for (int i = slot; i + 1 < held_n; i++) held[i] = held[i+1];
            held_n--;
            r.status = ST_DELETED;
          end else begin
            r.status = ST_NOT_FOUND;
            misses++;
          end
        end
        REQ_CLEAR: begin
          held_n   = 0;
          r.status = ST_CLEARED;
        end
        default: begin
          r.status = ST_READ_DONE;
          if (pos < held_n) begin
            r.rd_value = held[pos];
            r.rd_valid = 1'b1;
            good_reads++;
          end
        end
      endcase
      r.count = held_n[6:0];
      owed_q.push_back(r);
    endfunction

    // accepted result beat: compare with the oldest owed result
    function void check_result(status_t st, logic [6:0] cnt, logic [31:0] rv, logic rvalid);
      list_result_t w;
      if (owed_q.size() == 0) begin
        $display("%0t: result beat with none owed (status %0d count %0d)", $time, st, cnt);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      if (st !== w.status) begin
        $display("%0t: status expected %0d got %0d", $time, w.status, st);
        errors++;
      end
      if (cnt !== w.count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, w.count, cnt);
        errors++;
      end
      if (rv !== w.rd_value) begin
        $display("%0t: read_value expected %h got %h", $time, w.rd_value, rv);
        errors++;
      end
      if (rvalid !== w.rd_valid) begin
        $display("%0t: read_valid expected %0d got %0d", $time, w.rd_valid, rvalid);
        errors++;
      end
    endfunction

    // a value currently in the list, so that deletes can hit
    function logic [31:0] pick_held();
      if (held_n == 0) return $urandom;
      return held[$urandom_range(0, held_n - 1)];
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [31:0] value, [37:32] position, [39:38] zero
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [6:0] entry_count, [38:7] read_value, [39] zero
  logic [3:0]  out_tuser;  // [2:0] status, [3] read_valid

  list_scoreboard sb = new();
  bit             calm;    // set for stretches with no idling on either side

  sorted_list_insert_delete i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitor: both handshakes are sampled at the edge, before the block's
  // registers move. Results are checked before the new request is noted;
  // a result can never belong to a request accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(status_t'(out_tuser[2:0]), out_tdata[6:0], out_tdata[38:7],
                        out_tuser[3]);
      if (in_tvalid && in_tready)
        sb.note_request(req_t'(in_tuser), in_tdata[31:0], in_tdata[37:32]);
    end
  end

  // Drive one request beat. Valid is left high after acceptance so that a
  // back-to-back beat needs no second assignment in the same step.
  task automatic send_req(req_t kind, logic [31:0] v, logic [5:0] pos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, pos, v};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Receiver: before each result beat, hold ready low for a random stall.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Random request whose mix depends on the phase:
  // 0 fills towards full, 1 drains, 2 is an even mix.
  task automatic random_req(int mode);
    int          roll;
    req_t        kind;
    logic [31:0] v;
    logic [5:0]  pos;
    roll = $urandom_range(0, 99);
    case (mode)
      0:       kind = roll < 70 ? REQ_INSERT : roll < 80 ? REQ_DELETE :
                      roll < 98 ? REQ_READ : REQ_CLEAR;
      1:       kind = roll < 15 ? REQ_INSERT : roll < 75 ? REQ_DELETE :
                      roll < 98 ? REQ_READ : REQ_CLEAR;
      default: kind = roll < 40 ? REQ_INSERT : roll < 70 ? REQ_DELETE :
                      roll < 97 ? REQ_READ : REQ_CLEAR;
    endcase
    // value: full range, a narrow band for duplicates, the extremes, or one
    // already held
    roll = $urandom_range(0, 99);
    if (roll < 35)      v = $urandom;
    else if (roll < 60) v = $urandom_range(0, 16) - 8;
    else if (roll < 66) v = roll[0] ? 32'h7fff_ffff : 32'h8000_0000;
    else                v = sb.pick_held();
    if (kind == REQ_DELETE && $urandom_range(0, 9) < 7) v = sb.pick_held();
    // reads mostly inside the list, the rest anywhere in the field
    if (kind == REQ_READ && $urandom_range(0, 3) != 0 && sb.held_n > 0)
      pos = 6'($urandom_range(0, sb.held_n));
    else
      pos = 6'($urandom_range(0, 63));
    send_req(kind, v, pos);
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= REQ_INSERT;
    out_tready <= 1'b0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list cases, extremes, duplicates, reads at and past
    // the end, deletes of the first duplicate and of the extremes
    send_req(REQ_READ,   32'h0000_0000, 6'd0);
    send_req(REQ_READ,   32'hffff_ffff, 6'd63);
    send_req(REQ_DELETE, 32'h0000_0005, 6'd0);
    send_req(REQ_CLEAR,  32'h0000_0000, 6'd0);
    send_req(REQ_INSERT, 32'h0000_0000, 6'd0);
    send_req(REQ_INSERT, 32'h7fff_ffff, 6'd0);
    send_req(REQ_INSERT, 32'h8000_0000, 6'd0);
    send_req(REQ_INSERT, 32'hffff_ffff, 6'd0);
    send_req(REQ_INSERT, 32'h0000_0000, 6'd63);
    send_req(REQ_INSERT, 32'h0000_0001, 6'd0);
    send_req(REQ_READ,   32'h0000_0000, 6'd0);
    send_req(REQ_READ,   32'h0000_0000, 6'd5);
    send_req(REQ_READ,   32'h0000_0000, 6'd6);
    send_req(REQ_READ,   32'h0000_0000, 6'd63);
    send_req(REQ_DELETE, 32'h0000_0000, 6'd0);
    send_req(REQ_DELETE, 32'h0000_0002, 6'd0);
    send_req(REQ_DELETE, 32'h7fff_ffff, 6'd0);
    send_req(REQ_DELETE, 32'h8000_0000, 6'd0);
    send_req(REQ_READ,   32'h0000_0000, 6'd0);
    send_req(REQ_INSERT, 32'h5555_5555, 6'd42);
    send_req(REQ_INSERT, 32'haaaa_aaaa, 6'd21);
    send_req(REQ_READ,   32'h0000_0000, 6'd1);
    send_req(REQ_CLEAR,  32'h0000_0000, 6'd0);
    send_req(REQ_READ,   32'h0000_0000, 6'd0);

    // random phases, about 150 beats each
    for (int ph = 0; ph < 11; ph++) begin
      calm = (ph == 4 || ph == 8);
      if (ph == 6) begin
        // hold off the sender until the block has answered everything;
        // first wait on the clock so the last accepted beat is already noted
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.owed_q.size() != 0) @(posedge clk);
      end
      for (int n = 0; n < 150; n++) random_req(ph % 3);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d inserts (%0d dropped on full), %0d deletes (%0d not found)",
             sb.kind_hits[REQ_INSERT], sb.full_drops, sb.kind_hits[REQ_DELETE], sb.misses);
    $display("tb: %0d clears, %0d reads (%0d inside the list)",
             sb.kind_hits[REQ_CLEAR], sb.kind_hits[REQ_READ], sb.good_reads);
    if (sb.owed_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.owed_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t: watchdog expired, %0d results owed", $time, sb.owed_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule
